// ----- hw/rtl/rpn_pkg.sv -----
// Shared constants, codes and saturation helper for the postfix evaluator.
package rpn_pkg;

  localparam int STACK_DEPTH_DEF = 16;

  localparam logic [2:0] CMD_NUM = 3'd0;
  localparam logic [2:0] CMD_ADD = 3'd1;
  localparam logic [2:0] CMD_SUB = 3'd2;
  localparam logic [2:0] CMD_MUL = 3'd3;
  localparam logic [2:0] CMD_DIV = 3'd4;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_DIVZ  = 2'd3
  } status_t;

  localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] Q_MIN = 32'sh80000000;

  localparam logic signed [47:0] SAT_HI = 48'sh00007fffffff;
  localparam logic signed [47:0] SAT_LO = 48'shffff80000000;

  function automatic logic signed [31:0] sat48(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > SAT_HI) begin
      r = Q_MAX;
    end else if (v < SAT_LO) begin
      r = Q_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/rpn_in_if.sv -----
// Token channel: valid/ready handshake carrying one postfix token per beat.
interface rpn_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         cmd;
  logic signed [15:0] value;
  logic               last;

  modport source (output valid, output cmd, output value, output last, input ready);
  modport sink (input valid, input cmd, input value, input last, output ready);
endinterface

// ----- hw/rtl/rpn_out_if.sv -----
// Result channel: valid/ready handshake carrying one evaluated expression per beat.
interface rpn_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result;
  logic [1:0]         status;

  modport source (output valid, output result, output status, input ready);
  modport sink (input valid, input result, input status, output ready);
endinterface

// ----- hw/rtl/rpn_stack_evaluator.sv -----
// Postfix expression evaluator over a Q16.16 operand stack with a shared ALU sequencer.
//
// The block takes one token at a time and is not ready while a token is being
// worked on. Every token passes through dispatch and finish; between them an add
// or subtract runs add and write, a multiply mul, mulfix and write, and a divide
// divset, divrun, divfix and write, or divset and write alone on a divide by zero
// or a quotient too wide for the divider. The restoring divider retires one
// quotient bit per cycle through the same adder that serves add and subtract.
// A last token loads one result beat into the output register; the next token is
// accepted while that beat waits; a later last token waits for the register to free.
module rpn_stack_evaluator import rpn_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  rpn_in_if.sink     token,
  rpn_out_if.source  answer
);

  localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_DISPATCH = 10'b0000000010,
    S_ADD      = 10'b0000000100,
    S_MUL      = 10'b0000001000,
    S_MULFIX   = 10'b0000010000,
    S_DIVSET   = 10'b0000100000,
    S_DIVRUN   = 10'b0001000000,
    S_DIVFIX   = 10'b0010000000,
    S_WRITE    = 10'b0100000000,
    S_FINISH   = 10'b1000000000
  } state_t;

  state_t state;

  logic [2:0]         tok_cmd;
  logic signed [15:0] tok_value;
  logic               tok_last;

  logic [CNT_W-1:0]   count;
  status_t            err;
  logic signed [31:0] top;
  logic signed [31:0] left_op;
  logic signed [31:0] right_op;
  logic signed [31:0] op_res;
  logic signed [63:0] prod;
  logic [31:0]        rem;
  logic [31:0]        quo;
  logic [31:0]        dsr;
  logic [4:0]         iter;

  logic signed [31:0] mem [STACK_DEPTH];
  logic signed [31:0] rd_left;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_wa;
  logic signed [31:0] mem_wd;
  logic [CNT_W-1:0]   count_m2;

  logic signed [33:0] alu_a;
  logic signed [33:0] alu_b;
  logic               alu_sub;
  logic signed [33:0] alu_sum;

  logic [31:0]        lmag;
  logic [31:0]        rmag;
  logic signed [63:0] prod_adj;
  logic               out_free;
  logic               emit;

  assign count_m2 = count - CNT_W'(2);
  assign lmag     = left_op[31] ? 32'(-left_op) : 32'(left_op);
  assign rmag     = right_op[31] ? 32'(-right_op) : 32'(right_op);
  assign prod_adj = prod + (prod[63] ? 64'sd65535 : 64'sd0);
  assign out_free = !answer.valid || answer.ready;
  assign emit     = (state == S_FINISH) && tok_last && out_free;

  assign token.ready = (state == S_IDLE);

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state)
      S_ADD: begin
        alu_a   = 34'(left_op);
        alu_b   = 34'(right_op);
        alu_sub = (tok_cmd == CMD_SUB);
      end
      S_DIVRUN: begin
        alu_a   = {1'b0, rem, quo[31]};
        alu_b   = {2'b00, dsr};
        alu_sub = 1'b1;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
    alu_sum = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = count[IDX_W-1:0];
    mem_wd = {tok_value, 16'h0000};
    case (state)
      S_DISPATCH: begin
        mem_we = (tok_cmd == CMD_NUM) && (count < CNT_W'(STACK_DEPTH));
      end
      S_WRITE: begin
        mem_we = 1'b1;
        mem_wa = count_m2[IDX_W-1:0];
        mem_wd = op_res;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_left <= mem[count_m2[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      err          <= ST_OK;
      answer.valid <= 1'b0;
    end else begin
      if (emit) begin
        answer.valid <= 1'b1;
      end else if (answer.valid && answer.ready) begin
        answer.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (token.valid) begin
            tok_cmd   <= token.cmd;
            tok_value <= token.value;
            tok_last  <= token.last;
            state     <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          left_op  <= rd_left;
          right_op <= top;
          state    <= S_FINISH;
          if (tok_cmd == CMD_NUM) begin
            if (count < CNT_W'(STACK_DEPTH)) begin
              top   <= {tok_value, 16'h0000};
              count <= count + CNT_W'(1);
            end else if (err == ST_OK) begin
              err <= ST_OVER;
            end
          end else if (tok_cmd == CMD_ADD || tok_cmd == CMD_SUB ||
                       tok_cmd == CMD_MUL || tok_cmd == CMD_DIV) begin
            if (count < CNT_W'(2)) begin
              if (err == ST_OK) begin
                err <= ST_UNDER;
              end
            end else if (tok_cmd == CMD_MUL) begin
              state <= S_MUL;
            end else if (tok_cmd == CMD_DIV) begin
              state <= S_DIVSET;
            end else begin
              state <= S_ADD;
            end
          end
        end
        S_ADD: begin
          op_res <= sat48(48'(alu_sum));
          state  <= S_WRITE;
        end
        S_MUL: begin
          prod  <= left_op * right_op;
          state <= S_MULFIX;
        end
        S_MULFIX: begin
          op_res <= sat48(prod_adj[63:16]);
          state  <= S_WRITE;
        end
        S_DIVSET: begin
          dsr  <= rmag;
          rem  <= {16'h0000, lmag[31:16]};
          quo  <= {lmag[15:0], 16'h0000};
          iter <= '0;
          if (right_op == 32'sd0) begin
            op_res <= left_op[31] ? Q_MIN : Q_MAX;
            state  <= S_WRITE;
            if (err == ST_OK) begin
              err <= ST_DIVZ;
            end
          end else if ({16'h0000, lmag[31:16]} >= rmag) begin
            op_res <= (left_op[31] ^ right_op[31]) ? Q_MIN : Q_MAX;
            state  <= S_WRITE;
          end else begin
            state <= S_DIVRUN;
          end
        end
        S_DIVRUN: begin
          if (!alu_sum[33]) begin
            rem <= alu_sum[31:0];
            quo <= {quo[30:0], 1'b1};
          end else begin
            rem <= {rem[30:0], quo[31]};
            quo <= {quo[30:0], 1'b0};
          end
          iter <= iter + 5'd1;
          if (iter == 5'd31) begin
            state <= S_DIVFIX;
          end
        end
        S_DIVFIX: begin
          if (left_op[31] ^ right_op[31]) begin
            op_res <= (quo > 32'h80000000) ? Q_MIN : 32'(-quo);
          end else begin
            op_res <= quo[31] ? Q_MAX : 32'(quo);
          end
          state <= S_WRITE;
        end
        S_WRITE: begin
          top   <= op_res;
          count <= count - CNT_W'(1);
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!tok_last) begin
            state <= S_IDLE;
          end else if (out_free) begin
            if (count == '0) begin
              answer.result <= 32'sd0;
              answer.status <= (err == ST_OK) ? ST_UNDER : err;
            end else begin
              answer.result <= top;
              answer.status <= err;
            end
            count <= '0;
            err   <= ST_OK;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    token.valid && token.ready |=> state == S_DISPATCH)
    else $error("accepted token did not start dispatch");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_emit_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(answer.valid) |-> $past(state == S_FINISH))
    else $error("result beat raised outside finish");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    state == S_DIVRUN |-> rem < dsr)
    else $error("divider remainder not below divisor");

endmodule

// ----- bench/rpn_stack_evaluator_test.sv -----
// Self-checking testbench for rpn_stack_evaluator: token stimulus, Q16.16 stack predictor, answer checks.
module rpn_stack_evaluator_test;
  import rpn_pkg::*;

  localparam logic [2:0] CMD_UNUSED = 3'd5;
  localparam logic [2:0] CMD_TOP = 3'd7;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic signed [31:0] result;
    status_t            status;
  } answer_t;

  logic clk;
  logic rst;

  rpn_in_if  token();
  rpn_out_if answer();

  rpn_stack_evaluator i_dut (
    .clk    (clk),
    .rst    (rst),
    .token  (token),
    .answer (answer)
  );

  logic signed [31:0] opnd_stack [STACK_DEPTH_DEF];
  int                 opnd_count = 0;
  status_t            sticky_status = ST_OK;
  answer_t            results_due [$];

  bit steady_flow = 1'b0;
  int n_tokens = 0;
  int n_results = 0;
  int n_saturated = 0;
  int status_seen [4] = '{0, 0, 0, 0};
  int errors = 0;
  int idle_cycles = 0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic signed [31:0] clamp_q(input longint v);
    logic signed [31:0] r;
    if (v > longint'(Q_MAX)) begin
      r = Q_MAX;
      n_saturated++;
    end else if (v < longint'(Q_MIN)) begin
      r = Q_MIN;
      n_saturated++;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic void raise_status(input status_t code);
    if (sticky_status == ST_OK) begin
      sticky_status = code;
    end
  endfunction

  // Applies one accepted token to the stack copy and queues the answer a last token yields.
  function automatic void eval_token(input logic [2:0] cmd, input logic signed [15:0] value,
                                     input logic last);
    logic signed [31:0] right;
    logic signed [31:0] left;
    longint             r;
    answer_t            ans;
    if (cmd == CMD_NUM) begin
      if (opnd_count >= STACK_DEPTH_DEF) begin
        raise_status(ST_OVER);
      end else begin
        opnd_stack[opnd_count] = {value, 16'h0000};
        opnd_count++;
      end
    end else if (cmd inside {CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV}) begin
      if (opnd_count < 2) begin
        raise_status(ST_UNDER);
      end else begin
        right = opnd_stack[opnd_count - 1];
        left = opnd_stack[opnd_count - 2];
        case (cmd)
          CMD_ADD: begin
            r = longint'(left) + longint'(right);
          end
          CMD_SUB: begin
            r = longint'(left) - longint'(right);
          end
          CMD_MUL: begin
            r = (longint'(left) * longint'(right)) / 65536;
          end
          default: begin
            if (right == 0) begin
              raise_status(ST_DIVZ);
              r = (left < 0) ? longint'(Q_MIN) : longint'(Q_MAX);
            end else begin
              r = (longint'(left) * 65536) / longint'(right);
            end
          end
        endcase
        opnd_count--;
        opnd_stack[opnd_count - 1] = clamp_q(r);
      end
    end
    if (last) begin
      if (opnd_count == 0) begin
        raise_status(ST_UNDER);
        ans.result = '0;
      end else begin
        ans.result = opnd_stack[opnd_count - 1];
      end
      ans.status = sticky_status;
      results_due.push_back(ans);
      status_seen[ans.status]++;
      opnd_count = 0;
      sticky_status = ST_OK;
    end
  endfunction

  task automatic send_token(input logic [2:0] cmd, input logic signed [15:0] value,
                            input logic last);
    if (!steady_flow) begin
      while ($urandom_range(99) < 25) begin
        token.valid <= 1'b0;
        @(posedge clk);
      end
    end
    token.valid <= 1'b1;
    token.cmd <= cmd;
    token.value <= value;
    token.last <= last;
    @(posedge clk);
    while (!token.ready) begin
      @(posedge clk);
    end
    eval_token(cmd, value, last);
    n_tokens++;
  endtask

  function automatic logic signed [15:0] pick_value();
    int x;
    case ($urandom_range(3))
      0: x = int'($urandom_range(16)) - 8;
      1: x = int'($urandom_range(600)) - 300;
      default: x = int'($urandom_range(65535));
    endcase
    return x[15:0];
  endfunction

  // Sends one well-formed expression; now and then it leaves a spare entry below the top.
  task automatic send_expression(input int max_operands);
    int   n_num;
    int   pushed;
    int   depth;
    int   keep;
    logic is_op;
    logic is_final;
    n_num = $urandom_range(max_operands, 1);
    keep = (n_num > 2 && $urandom_range(9) == 0) ? 2 : 1;
    pushed = 0;
    depth = 0;
    while (pushed < n_num || depth > keep) begin
      is_op = depth >= 2 && (pushed == n_num || $urandom_range(1) == 1);
      if (is_op) begin
        is_final = pushed == n_num && depth - 1 <= keep;
        send_token(CMD_ADD + 3'($urandom_range(3)), pick_value(), is_final);
        depth--;
      end else begin
        is_final = pushed + 1 == n_num && depth + 1 <= keep;
        send_token(CMD_NUM, pick_value(), is_final);
        pushed++;
        depth++;
      end
    end
  endtask

  task automatic test_extreme_operands();
    send_token(CMD_NUM, 16'sh7fff, 1'b0);
    send_token(CMD_NUM, 16'sh8000, 1'b0);
    send_token(CMD_ADD, 16'sh0000, 1'b1);
    send_token(CMD_NUM, 16'sh7fff, 1'b0);
    send_token(CMD_NUM, 16'sh7fff, 1'b0);
    send_token(CMD_MUL, 16'shffff, 1'b1);
    send_token(CMD_NUM, 16'sh8000, 1'b0);
    send_token(CMD_NUM, 16'sh7fff, 1'b0);
    send_token(CMD_SUB, 16'sh0000, 1'b1);
    send_token(CMD_NUM, 16'sh0001, 1'b0);
    send_token(CMD_NUM, 16'sh0003, 1'b0);
    send_token(CMD_DIV, 16'sh0000, 1'b1);
    send_token(CMD_NUM, 16'shffff, 1'b0);
    send_token(CMD_NUM, 16'sh0003, 1'b0);
    send_token(CMD_DIV, 16'sh0000, 1'b1);
  endtask

  task automatic test_error_cases();
    send_token(CMD_NUM, -16'sd5, 1'b0);
    send_token(CMD_NUM, 16'sh0000, 1'b0);
    send_token(CMD_DIV, 16'sh0000, 1'b1);
    // The first error wins: underflow stays when a zero divisor follows.
    send_token(CMD_NUM, 16'sh0001, 1'b0);
    send_token(CMD_ADD, 16'sh0000, 1'b0);
    send_token(CMD_NUM, 16'sh0000, 1'b0);
    send_token(CMD_DIV, 16'sh0000, 1'b1);
    send_token(CMD_NUM, 16'sh0003, 1'b0);
    send_token(CMD_UNUSED, 16'sh1234, 1'b1);
    send_token(CMD_TOP, 16'sh0000, 1'b1);
    send_token(CMD_NUM, 16'sh0001, 1'b0);
    send_token(CMD_NUM, 16'sh0002, 1'b1);
  endtask

  task automatic test_random_expressions(input int stop_at);
    while (n_tokens < stop_at) begin
      send_expression($urandom_range(9) == 0 ? STACK_DEPTH_DEF : 6);
    end
  endtask

  task automatic test_back_to_back(input int stop_at);
    steady_flow = 1'b1;
    while (n_tokens < stop_at) begin
      send_expression(5);
    end
    steady_flow = 1'b0;
  endtask

  // Loose tokens, stack overruns and operators on a short stack.
  task automatic test_malformed(input int stop_at);
    int n;
    while (n_tokens < stop_at) begin
      case ($urandom_range(3))
        0: begin
          n = $urandom_range(STACK_DEPTH_DEF + 4, STACK_DEPTH_DEF - 1);
          repeat (n) begin
            send_token(CMD_NUM, pick_value(), 1'b0);
          end
          if ($urandom_range(1) == 1) begin
            send_token(CMD_ADD + 3'($urandom_range(3)), pick_value(), 1'b0);
          end
          send_token(3'($urandom_range(7)), pick_value(), 1'b1);
        end
        1: begin
          send_token(CMD_NUM, pick_value(), 1'b0);
          send_token(CMD_ADD + 3'($urandom_range(3)), pick_value(), 1'b0);
          send_expression(4);
        end
        default: begin
          repeat ($urandom_range(6, 1)) begin
            send_token(3'($urandom_range(7)), pick_value(), $urandom_range(3) == 0);
          end
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    answer.ready <= steady_flow || ($urandom_range(99) >= 25);
  end

  always @(posedge clk) begin : check_answers
    answer_t want;
    if (!rst && answer.valid && answer.ready) begin
      n_results++;
      if (results_due.size() == 0) begin
        $display("%0t: unexpected answer beat, result %0d status %0d", $time,
                 answer.result, answer.status);
        errors++;
      end else begin
        want = results_due.pop_front();
        if (answer.result !== want.result) begin
          $display("%0t: result mismatch, expected %0d got %0d", $time, want.result,
                   answer.result);
          errors++;
        end
        if (answer.status !== want.status) begin
          $display("%0t: status mismatch, expected %0d got %0d", $time, want.status,
                   answer.status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (token.valid && token.ready) || (answer.valid && answer.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles, %0d answers outstanding", $time, idle_cycles,
               results_due.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    token.valid = 1'b0;
    token.cmd = CMD_NUM;
    token.value = '0;
    token.last = 1'b0;
    repeat (11) begin
      @(posedge clk);
    end
    rst <= 1'b0;
    @(posedge clk);

    test_extreme_operands();
    test_error_cases();
    test_random_expressions(900);
    test_back_to_back(1050);
    test_malformed(1350);

    token.valid <= 1'b0;
    while (results_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) begin
      @(posedge clk);
    end

    $display("Sent %0d tokens and checked %0d answers; %0d intermediate values saturated.",
             n_tokens, n_results, n_saturated);
    $display("Answer status counts: ok %0d, underflow %0d, overflow %0d, divide by zero %0d.",
             status_seen[ST_OK], status_seen[ST_UNDER], status_seen[ST_OVER],
             status_seen[ST_DIVZ]);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
